// ===== rtl/ssd_pkg.sv =====
// Shared types, constants and segment decoding for the seven-segment scan driver.
package ssd_pkg;

   localparam int DIGIT_COUNT = 2;
   localparam int SEG_BITS    = 8;
   localparam int CNT_BITS    = 4;

   // Index of the latch result within a nine-result run
   localparam logic [CNT_BITS-1:0] LATCH_STEP = 4'd8;

   // Command codes carried on req_tuser
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Configuration register indexes
   localparam logic CSR_SHOW_C_MARK = 1'b0;
   localparam logic CSR_SHOW_H_MARK = 1'b1;

   typedef struct packed {
      logic [SEG_BITS-1:0]    seg_byte;
      logic [DIGIT_COUNT-1:0] dig_shift;
      logic [DIGIT_COUNT-1:0] dig_latch;
   } ssd_job_type;

   // Segments G..A for one ASCII code; unknown codes are blank
   function automatic logic [6:0] seg_decode(input logic [7:0] code);
      logic [6:0] seg;
      case (code)
         "0":     seg = 7'b0111111;
         "1":     seg = 7'b0000110;
         "2":     seg = 7'b1011011;
         "3":     seg = 7'b1001111;
         "4":     seg = 7'b1100110;
         "5":     seg = 7'b1101101;
         "6":     seg = 7'b1111101;
         "7":     seg = 7'b0000111;
         "8":     seg = 7'b1111111;
         "9":     seg = 7'b1101111;
         "E":     seg = 7'b1111001;
         default: seg = 7'b0000000;
      endcase
      return seg;
   endfunction

endpackage

// ===== rtl/ssd_lane.sv =====
// One character lane: decodes a character into a segment byte with its mark bit.
module ssd_lane (
   input  logic [7:0] char_code,
   input  logic       char_valid,
   input  logic       mark,
   output logic [7:0] seg_byte
);
   import ssd_pkg::*;

   assign seg_byte = {(char_valid ? seg_decode(char_code) : 7'b0000000), mark};

endmodule

// ===== rtl/ssd_serializer.sv =====
// Serializer: turns a queued byte job into eight shift results and one latch result.
module ssd_serializer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  ssd_pkg::ssd_job_type push_job,
   output logic                 pend_full,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,  // serial_bit, shift_pulse, latch_pulse, digit_on[4:3], pad
   output logic                 rsp_tlast
);
   import ssd_pkg::*;

   ssd_job_type         job_ff, job_in;
   ssd_job_type         pend_ff, pend_in;
   logic                busy_ff, busy_in;
   logic                pend_v_ff, pend_v_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                at_latch;
   logic                finish;
   logic                step;

   assign at_latch = (cnt_ff == LATCH_STEP);
   assign finish   = busy_ff & rsp_tready & at_latch;
   assign step     = busy_ff & rsp_tready & ~at_latch;

   always_comb begin
      job_in    = job_ff;
      pend_in   = pend_ff;
      busy_in   = busy_ff;
      pend_v_in = pend_v_ff;
      cnt_in    = cnt_ff;
      if (step) begin
         job_in.seg_byte = {job_ff.seg_byte[SEG_BITS-2:0], 1'b0};
         cnt_in          = cnt_ff + 1'b1;
      end
      if (finish) begin
         if (pend_v_ff) begin
            job_in    = pend_ff;
            cnt_in    = '0;
            pend_v_in = 1'b0;
         end else begin
            busy_in = 1'b0;
         end
      end
      // a new job goes straight to the output stage if it is free this cycle
      if (push_valid) begin
         if (!busy_ff || (finish && !pend_v_ff)) begin
            job_in  = push_job;
            cnt_in  = '0;
            busy_in = 1'b1;
         end else begin
            pend_in   = push_job;
            pend_v_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         pend_v_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         busy_ff   <= busy_in;
         pend_v_ff <= pend_v_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      pend_ff <= pend_in;
   end

   assign pend_full  = pend_v_ff;
   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = at_latch;
   assign rsp_tdata  = {3'b000,
                        (at_latch ? job_ff.dig_latch : job_ff.dig_shift),
                        at_latch,
                        ~at_latch,
                        (~at_latch & job_ff.seg_byte[SEG_BITS-1])};

endmodule

// ===== rtl/seven_segment_scan_driver.sv =====
// Top level: two-digit multiplexed seven-segment driver for a serial-in latch-out register.
// A tick or a pause while running yields nine results, one per cycle when rsp_tready is high;
// the first appears the cycle after acceptance if the serializer is free, else once the run
// ahead ends. Other writes yield no result. One further item is taken while a run is being
// emitted (a one-job queue ahead of the serializer); the shift/latch sequence paces ticks.
// Synchronous reset: display paused, store and marks zero, scan at the first digit.
module seven_segment_scan_driver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // char_first[7:0], char_second[15:8], text_length[17:16], pad
   input  logic        req_tuser,  // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // serial_bit, shift_pulse, latch_pulse, digit_on[4:3], pad
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic        csr_wdata
);
   import ssd_pkg::*;

   logic                   show_c_ff, show_h_ff;
   logic [SEG_BITS-1:0]    store_ff [DIGIT_COUNT];
   logic [SEG_BITS-1:0]    store_in [DIGIT_COUNT];
   logic                   running_ff, running_in;
   logic                   scan_ff, scan_in;
   logic [DIGIT_COUNT-1:0] lit_ff, lit_in;

   logic [SEG_BITS-1:0]    lane_byte [DIGIT_COUNT];
   logic [1:0]             text_length;
   logic                   accepted;
   logic                   push_valid;
   ssd_job_type            push_job;
   logic                   pend_full;
   logic [DIGIT_COUNT-1:0] scan_onehot;

   assign text_length = req_tdata[17:16];
   assign req_tready  = ~pend_full;
   assign accepted    = req_tvalid & req_tready;
   assign scan_onehot = scan_ff ? 2'b10 : 2'b01;

   // lanes: length three saturates to two, so the second char is valid on bit 1 alone
   ssd_lane u_lane0 (
      .char_code  (req_tdata[7:0]),
      .char_valid (text_length != 2'b00),
      .mark       (show_c_ff),
      .seg_byte   (lane_byte[0])
   );

   ssd_lane u_lane1 (
      .char_code  (req_tdata[15:8]),
      .char_valid (text_length[1]),
      .mark       (show_h_ff),
      .seg_byte   (lane_byte[1])
   );

   // merge: store update and job selection
   always_comb begin
      store_in   = store_ff;
      running_in = running_ff;
      scan_in    = scan_ff;
      lit_in     = lit_ff;
      push_valid = 1'b0;
      push_job   = '{seg_byte: store_ff[scan_ff], dig_shift: lit_ff, dig_latch: scan_onehot};
      if (accepted) begin
         if (req_tuser == CMD_WRITE) begin
            if (text_length == 2'b00) begin
               if (running_ff) begin
                  push_valid = 1'b1;
                  push_job   = '{seg_byte: '0, dig_shift: '0, dig_latch: '0};
                  store_in   = '{default: '0};
                  running_in = 1'b0;
                  lit_in     = '0;
               end
            end else begin
               store_in   = lane_byte;
               running_in = 1'b1;
            end
         end else if (running_ff) begin
            push_valid = 1'b1;
            lit_in     = scan_onehot;
            scan_in    = ~scan_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         show_c_ff  <= 1'b0;
         show_h_ff  <= 1'b0;
         store_ff   <= '{default: '0};
         running_ff <= 1'b0;
         scan_ff    <= 1'b0;
         lit_ff     <= '0;
      end else begin
         if (csr_we && csr_index == CSR_SHOW_C_MARK) begin
            show_c_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_SHOW_H_MARK) begin
            show_h_ff <= csr_wdata;
         end
         store_ff   <= store_in;
         running_ff <= running_in;
         scan_ff    <= scan_in;
         lit_ff     <= lit_in;
      end
   end

   ssd_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pend_full  (pend_full),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // paused display never has a digit lit
   assert property (@(posedge clock) disable iff (reset) !running_ff |-> lit_ff == '0)
      else $error("digit lit while paused");

   // input stalls only while a run is in progress
   assert property (@(posedge clock) disable iff (reset) !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

   // a latch lights at most one digit
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid && rsp_tlast |-> $onehot0(rsp_tdata[4:3]))
      else $error("latch lights more than one digit");

   // a job (tick or pause) that starts a run while idle shows its first result next cycle
   assert property (@(posedge clock) disable iff (reset)
                    push_valid && !rsp_tvalid |=> rsp_tvalid && !rsp_tlast)
      else $error("run did not start");

endmodule
